// File: rtl/core/acfp_pkg.sv
`timescale 1ns / 1ps

package acfp_pkg;

   // Byte limits per frame kind
   localparam int MAX_DATA_BYTES     = 64;
   localparam int CLASSIC_DATA_BYTES = 8;

   localparam int BYTE_AW  = $clog2(MAX_DATA_BYTES);   // address within one bank
   localparam int STORE_AW = BYTE_AW + 1;              // two banks
   localparam int LEN_W    = 7;                         // 0..64
   localparam int IDX_W    = 6;

   // Characters
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_R_UPPER = 8'h52;
   localparam logic [7:0] CH_R_LOWER = 8'h72;

   // Identifier flag bits
   localparam int FLAG_EFF_BIT = 31;
   localparam int FLAG_RTR_BIT = 30;
   localparam int FLAG_ERR_BIT = 29;

   // Verdict codes
   localparam logic [1:0] VERDICT_INVALID = 2'd0;
   localparam logic [1:0] VERDICT_CLASSIC = 2'd1;
   localparam logic [1:0] VERDICT_FD      = 2'd2;

   typedef struct packed {
      logic [7:0] character;
      logic       terminator;
   } req_type;

   typedef struct packed {
      logic [1:0]       verdict;
      logic [31:0]      frame_id;
      logic [3:0]       fd_flags;
      logic [LEN_W-1:0] data_length;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       data_byte;
      logic             last;
   } rsp_type;

   // One parsed frame, handed from parser to drain
   typedef struct packed {
      logic [1:0]       verdict;
      logic [31:0]      frame_id;
      logic [3:0]       fd_flags;
      logic [LEN_W-1:0] data_length;
      logic [LEN_W-1:0] byte_count;   // data bytes to read from the store
      logic             bank;
   } desc_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_wr_type;

   // Hex digit value; bit 4 set means not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 5'(c - 8'h61 + 8'd10);
      end
      return v;
   endfunction

endpackage

// File: rtl/core/ascii_can_frame_parser.sv
`timescale 1ns / 1ps

// Parses the text form of a CAN frame ("ID#data" or "ID##Fdata"), one
// character per request, with a terminator request closing the string.
// Characters are taken one per cycle while req_ready is high. A terminator
// turns the parsed frame into a descriptor in a two-entry queue; the drain
// side then gives one result per cycle while rsp_ready is high, one per
// data byte (a single result when the frame has no data or is invalid),
// each going through a store read stage and an output register. Data bytes
// go to a store of two 64-byte banks, one being filled while the other
// drains, so req_ready drops only while two finished frames wait in the
// queue, i.e. while both banks are held; it returns the cycle after the
// older frame's last byte is read from the store.
// Identifier flags: bit 31 extended, bit 30 remote, bit 29 error.

module ascii_can_frame_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  acfp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output acfp_pkg::rsp_type rsp_payload
);
   import acfp_pkg::*;

   // parser to queue
   logic         push;
   desc_type     push_desc;
   logic         q_full;
   store_wr_type store_wr;

   // queue to drain
   logic         head_valid;
   desc_type     head_desc;
   logic         pop;

   // Front: classifies characters, fills the current data bank
   acfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push),
      .push_desc   (push_desc),
      .store_wr    (store_wr)
   );

   // Finished frames wait here; depth matches the number of banks
   acfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (q_full),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop)
   );

   // Back: walks each frame's bytes and drives the result channel
   acfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .store_wr    (store_wr),
      .head_valid  (head_valid),
      .head_desc   (head_desc),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/core/acfp_front.sv
`timescale 1ns / 1ps

module acfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  acfp_pkg::req_type     req_payload,
   input  logic                  q_full,
   output logic                  push,
   output acfp_pkg::desc_type    push_desc,
   output acfp_pkg::store_wr_type store_wr
);
   import acfp_pkg::*;

   typedef enum logic [9:0] {
      PH_ID       = 10'b00_0000_0001,
      PH_AFTER_ID = 10'b00_0000_0010,
      PH_FLAGS    = 10'b00_0000_0100,
      PH_DATA     = 10'b00_0000_1000,
      PH_DOTTED   = 10'b00_0001_0000,
      PH_LOW      = 10'b00_0010_0000,
      PH_FULL     = 10'b00_0100_0000,
      PH_RTR_DLC  = 10'b00_1000_0000,
      PH_DONE     = 10'b01_0000_0000,
      PH_BAD      = 10'b10_0000_0000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [3:0]       pos_ff, pos_in;
   logic [31:0]      id_ff, id_in;
   logic             err_ff, err_in;
   logic [3:0]       fd_ff, fd_in;
   logic             is_fd_ff, is_fd_in;
   logic [3:0]       hi_ff, hi_in;
   logic [LEN_W-1:0] bytes_ff, bytes_in;
   logic             bank_ff, bank_in;

   logic             accept;
   logic [7:0]       c;
   logic [4:0]       nib;
   logic [LEN_W-1:0] limit;
   logic [LEN_W-1:0] bytes_inc;
   logic             frame_ok;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign c         = req_payload.character;
   assign nib       = hex_value(c);
   assign limit     = is_fd_ff ? LEN_W'(MAX_DATA_BYTES) : LEN_W'(CLASSIC_DATA_BYTES);
   assign bytes_inc = bytes_ff + LEN_W'(1);

   assign frame_ok = (phase_ff == PH_AFTER_ID) || (phase_ff == PH_DATA) ||
                     (phase_ff == PH_DOTTED) || (phase_ff == PH_FULL) ||
                     (phase_ff == PH_RTR_DLC) || (phase_ff == PH_DONE);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      id_in     = id_ff;
      err_in    = err_ff;
      fd_in     = fd_ff;
      is_fd_in  = is_fd_ff;
      hi_in     = hi_ff;
      bytes_in  = bytes_ff;
      bank_in   = bank_ff;
      push      = 1'b0;
      push_desc = '0;
      store_wr  = '0;

      if (accept && !req_payload.terminator) begin
         case (phase_ff)
            PH_ID: begin
               if (pos_ff == 4'd3 && c == CH_HASH) begin
                  phase_in = err_ff ? PH_BAD : PH_AFTER_ID;
               end else if (pos_ff >= 4'd8) begin
                  if (c == CH_HASH && !err_ff) begin
                     if (!id_ff[FLAG_ERR_BIT]) begin
                        id_in[FLAG_EFF_BIT] = 1'b1;
                     end
                     phase_in = PH_AFTER_ID;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end else begin
                  if (nib[4]) begin
                     err_in = 1'b1;
                  end else begin
                     id_in = {id_ff[27:0], nib[3:0]};
                  end
                  pos_in = pos_ff + 4'd1;
               end
            end
            PH_AFTER_ID, PH_DATA: begin
               if (phase_ff == PH_AFTER_ID && (c == CH_R_UPPER || c == CH_R_LOWER)) begin
                  id_in[FLAG_RTR_BIT] = 1'b1;
                  phase_in = PH_RTR_DLC;
               end else if (phase_ff == PH_AFTER_ID && c == CH_HASH) begin
                  is_fd_in = 1'b1;
                  phase_in = PH_FLAGS;
               end else if (c == CH_DOT) begin
                  phase_in = PH_DOTTED;
               end else if (nib[4]) begin
                  phase_in = PH_BAD;
               end else begin
                  hi_in    = nib[3:0];
                  phase_in = PH_LOW;
               end
            end
            PH_FLAGS: begin
               if (nib[4]) begin
                  phase_in = PH_BAD;
               end else begin
                  fd_in    = nib[3:0];
                  phase_in = PH_DATA;
               end
            end
            PH_DOTTED: begin
               if (nib[4]) begin
                  phase_in = PH_BAD;
               end else begin
                  hi_in    = nib[3:0];
                  phase_in = PH_LOW;
               end
            end
            PH_LOW: begin
               if (nib[4]) begin
                  phase_in = PH_BAD;
               end else begin
                  store_wr.en   = 1'b1;
                  store_wr.addr = {bank_ff, bytes_ff[BYTE_AW-1:0]};
                  store_wr.data = {hi_ff, nib[3:0]};
                  bytes_in      = bytes_inc;
                  phase_in      = (bytes_inc >= limit) ? PH_FULL : PH_DATA;
               end
            end
            PH_RTR_DLC: begin
               if (nib <= 5'd8) begin
                  bytes_in = LEN_W'(nib);
               end
               phase_in = PH_DONE;
            end
            default: begin
               // full, done, bad: ignore until terminator
            end
         endcase
      end else if (accept) begin
         push = 1'b1;
         if (frame_ok) begin
            push_desc.verdict     = is_fd_ff ? VERDICT_FD : VERDICT_CLASSIC;
            push_desc.frame_id    = id_ff;
            push_desc.fd_flags    = fd_ff;
            push_desc.data_length = bytes_ff;
            push_desc.byte_count  = id_ff[FLAG_RTR_BIT] ? '0 : bytes_ff;
         end
         push_desc.bank = bank_ff;
         bank_in  = !bank_ff;
         phase_in = PH_ID;
         pos_in   = '0;
         id_in    = '0;
         err_in   = 1'b0;
         fd_in    = '0;
         is_fd_in = 1'b0;
         hi_in    = '0;
         bytes_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ID;
         pos_ff   <= '0;
         id_ff    <= '0;
         err_ff   <= 1'b0;
         fd_ff    <= '0;
         is_fd_ff <= 1'b0;
         hi_ff    <= '0;
         bytes_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         id_ff    <= id_in;
         err_ff   <= err_in;
         fd_ff    <= fd_in;
         is_fd_ff <= is_fd_in;
         hi_ff    <= hi_in;
         bytes_ff <= bytes_in;
         bank_ff  <= bank_in;
      end
   end

   // Full phase only once the byte limit for this frame kind is reached
   a_full_at_limit: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FULL) |-> (bytes_ff == limit))
      else $error("full phase with byte count off the limit");

   // Store writes stay inside the bank being filled
   a_write_own_bank: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |-> (store_wr.addr[STORE_AW-1] == bank_ff) && (bytes_ff < limit))
      else $error("data byte written outside current bank or past limit");

endmodule

// File: rtl/core/acfp_queue.sv
`timescale 1ns / 1ps

module acfp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  acfp_pkg::desc_type push_desc,
   output logic               full,
   output logic               head_valid,
   output acfp_pkg::desc_type head_desc,
   input  logic               pop
);
   import acfp_pkg::*;

   desc_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_desc  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// File: rtl/core/acfp_back.sv
`timescale 1ns / 1ps

module acfp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  acfp_pkg::store_wr_type store_wr,
   input  logic                   head_valid,
   input  acfp_pkg::desc_type     head_desc,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output acfp_pkg::rsp_type      rsp_payload
);
   import acfp_pkg::*;

   localparam int STORE_DEPTH = 2 * MAX_DATA_BYTES;

   logic [7:0]       store_ff [STORE_DEPTH];
   logic [7:0]       rd_data_ff;

   logic [BYTE_AW-1:0] k_ff, k_in;
   logic               s1_vld_ff, s1_vld_in;
   rsp_type            s1_rsp_ff;
   logic               s1_nodata_ff;
   logic               out_vld_ff, out_vld_in;
   rsp_type            out_ff, out_in;

   logic             issue;
   logic             load_out;
   logic [LEN_W-1:0] n_res;
   logic             is_last;
   rsp_type          s1_rsp_in;

   assign load_out = s1_vld_ff && (!out_vld_ff || rsp_ready);
   assign issue    = head_valid && (!s1_vld_ff || load_out);
   assign n_res    = (head_desc.byte_count == '0) ? LEN_W'(1) : head_desc.byte_count;
   assign is_last  = ({1'b0, k_ff} + LEN_W'(1)) == n_res;
   assign pop      = issue && is_last;

   always_comb begin
      k_in = k_ff;
      if (issue) begin
         k_in = is_last ? '0 : k_ff + BYTE_AW'(1);
      end
      s1_vld_in = issue ? 1'b1 : (load_out ? 1'b0 : s1_vld_ff);
      out_vld_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_vld_ff);

      s1_rsp_in.verdict     = head_desc.verdict;
      s1_rsp_in.frame_id    = head_desc.frame_id;
      s1_rsp_in.fd_flags    = head_desc.fd_flags;
      // for a run of data bytes, data_length equals the byte count
      s1_rsp_in.data_length = head_desc.data_length;
      s1_rsp_in.byte_index  = IDX_W'(k_ff);
      s1_rsp_in.data_byte   = '0;
      s1_rsp_in.last        = is_last;

      out_in           = s1_rsp_ff;
      out_in.data_byte = s1_nodata_ff ? 8'd0 : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff       <= '0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         k_ff       <= k_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Two-bank data store; parser fills one bank while the other drains
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_ff[store_wr.addr] <= store_wr.data;
      end
      if (issue) begin
         rd_data_ff <= store_ff[{head_desc.bank, k_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_rsp_ff    <= s1_rsp_in;
         s1_nodata_ff <= (head_desc.byte_count == '0);
      end
      if (load_out) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

   // A descriptor leaves the queue only with the final result of its run
   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> s1_vld_ff && s1_rsp_ff.last)
      else $error("descriptor popped without last result");

   // Read stage holds its data while the output register is stalled
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && out_vld_ff && !rsp_ready) |=> s1_vld_ff && $stable(rd_data_ff))
      else $error("read stage lost data under stall");

   // Invalid frames are a single result
   a_invalid_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.verdict == VERDICT_INVALID) |-> rsp_payload.last)
      else $error("invalid verdict not marked last");

   // Data results stay inside the frame's byte count
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.verdict != VERDICT_INVALID &&
       !rsp_payload.frame_id[FLAG_RTR_BIT] && rsp_payload.data_length != '0)
      |-> ({1'b0, rsp_payload.byte_index} < rsp_payload.data_length))
      else $error("byte index past data length");

endmodule

// File: tb/sv/ascii_can_frame_parser_tb.sv
`timescale 1ns / 1ps

module ascii_can_frame_parser_tb;
   import acfp_pkg::*;

   // No acceptance on either channel for this long means the block is stuck
   localparam int WATCHDOG_LIMIT = 2000;
   // Quiet cycles after the last result, to catch stray extra results
   localparam int SETTLE_CYCLES  = 32;
   // Random characters per pacing phase; the directed frames make up most
   // of the run
   localparam int PHASE_CHARS    = 15;

   // Parser phases of the local frame decoder
   typedef enum logic [9:0] {
      SCAN_IDENT     = 10'b00_0000_0001,  // collecting identifier digits
      SCAN_DELIM     = 10'b00_0000_0010,  // just past the '#' after the identifier
      SCAN_FLAGS     = 10'b00_0000_0100,  // just past "##", flags digit due
      SCAN_BYTE_HI   = 10'b00_0000_1000,  // high digit of a byte, or a dot, due
      SCAN_AFTER_DOT = 10'b00_0001_0000,  // dot seen, high digit due
      SCAN_BYTE_LO   = 10'b00_0010_0000,  // low digit of a byte due
      SCAN_FULL      = 10'b00_0100_0000,  // byte limit reached, rest ignored
      SCAN_DLC       = 10'b00_1000_0000,  // remote marker seen, DLC digit may follow
      SCAN_DONE      = 10'b01_0000_0000,  // remote frame closed, rest ignored
      SCAN_BAD       = 10'b10_0000_0000   // frame already invalid, rest ignored
   } scan_state_type;

   // One queued request plus whether the sender must first wait for the
   // result side to drain completely
   typedef struct {
      req_type payload;
      bit      hold;
   } pending_item_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   ascii_can_frame_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Frame decoder state, mirrored from the block's behaviour
   // ------------------------------------------------------------------
   scan_state_type scan_state;
   int unsigned id_digits;
   logic [31:0] id_acc;
   bit          id_bad;         // a non-hex identifier digit was seen
   logic [3:0]  flag_nibble;
   bit          fd_frame;
   logic [3:0]  hi_nibble;
   int unsigned byte_count;
   logic [7:0]  frame_bytes [64];

   rsp_type          bytes_due [$];  // results still owed by the block, oldest first
   pending_item_type pending [$];    // requests not yet presented
   pending_item_type head_item;

   bit          drained = 1'b1; // registered: nothing owed as of the last edge
   bit          hold_next = 1'b0;
   int unsigned send_gap_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned mismatches    = 0;
   int unsigned chars_queued  = 0;
   int unsigned requests_taken = 0;
   int unsigned frames_closed  = 0;
   int unsigned results_checked = 0;

   // Hex digit value; bit 4 set flags a non-hex character
   function automatic logic [4:0] nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b0, c[3:0]};
      end
      // 'A'..'F' and 'a'..'f' both end in 1..6
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
         return {1'b0, c[3:0]} + 5'd9;
      end
      return 5'h10;
   endfunction

   function void clear_scan();
      scan_state  = SCAN_IDENT;
      id_digits   = 0;
      id_acc      = '0;
      id_bad      = 1'b0;
      flag_nibble = '0;
      fd_frame    = 1'b0;
      hi_nibble   = '0;
      byte_count  = 0;
   endfunction

   function void take_high(logic [7:0] c);
      logic [4:0] n;
      n = nibble_of(c);
      if (n[4]) begin
         scan_state = SCAN_BAD;
      end else begin
         hi_nibble  = n[3:0];
         scan_state = SCAN_BYTE_LO;
      end
   endfunction

   function void take_data_char(logic [7:0] c);
      int unsigned cap;
      logic [4:0]  n;
      cap = fd_frame ? MAX_DATA_BYTES : CLASSIC_DATA_BYTES;
      case (scan_state)
         SCAN_BYTE_HI: begin
            if (c == CH_DOT) begin
               scan_state = SCAN_AFTER_DOT;
            end else begin
               take_high(c);
            end
         end
         // a second dot in a row is simply a bad high digit
         SCAN_AFTER_DOT: take_high(c);
         SCAN_BYTE_LO: begin
            n = nibble_of(c);
            if (n[4]) begin
               scan_state = SCAN_BAD;
            end else begin
               frame_bytes[byte_count % 64] = {hi_nibble, n[3:0]};
               byte_count++;
               scan_state = (byte_count >= cap) ? SCAN_FULL : SCAN_BYTE_HI;
            end
         end
         default: ;
      endcase
   endfunction

   function void take_ident_char(logic [7:0] c);
      logic [4:0] n;
      if (id_digits == 3 && c == CH_HASH) begin
         scan_state = id_bad ? SCAN_BAD : SCAN_DELIM;
      end else if (id_digits >= 8) begin
         // 8-digit form: a ninth character must be the delimiter
         if (c == CH_HASH && !id_bad) begin
            if (!id_acc[FLAG_ERR_BIT]) begin
               id_acc[FLAG_EFF_BIT] = 1'b1;
            end
            scan_state = SCAN_DELIM;
         end else begin
            scan_state = SCAN_BAD;
         end
      end else begin
         n = nibble_of(c);
         if (n[4]) begin
            id_bad = 1'b1;
         end else begin
            id_acc = {id_acc[27:0], n[3:0]};
         end
         id_digits++;
      end
   endfunction

   // Terminator: owe one result per data byte, or a single result
   function void close_frame();
      rsp_type     r;
      int unsigned n_out;
      bit          usable;
      r      = '0;
      r.last = 1'b1;
      case (scan_state)
         SCAN_DELIM, SCAN_BYTE_HI, SCAN_AFTER_DOT, SCAN_FULL, SCAN_DLC,
         SCAN_DONE: usable = 1'b1;
         default:   usable = 1'b0;
      endcase
      if (!usable) begin
         r.verdict = VERDICT_INVALID;
         bytes_due.push_back(r);
      end else begin
         r.verdict  = fd_frame ? VERDICT_FD : VERDICT_CLASSIC;
         r.frame_id = id_acc;
         r.fd_flags = flag_nibble;
         // remote bit (given or from the digits) means no payload bytes
         n_out = id_acc[FLAG_RTR_BIT] ? 0 : byte_count;
         if (n_out == 0) begin
            r.data_length = byte_count[LEN_W-1:0];
            bytes_due.push_back(r);
         end else begin
            for (int k = 0; k < n_out; k++) begin
               r.data_length = n_out[LEN_W-1:0];
               r.byte_index  = k[IDX_W-1:0];
               r.data_byte   = frame_bytes[k];
               r.last        = (k + 1 == n_out);
               bytes_due.push_back(r);
            end
         end
      end
      frames_closed++;
      clear_scan();
   endfunction

   function void parse_request(req_type q);
      logic [4:0] n;
      if (q.terminator) begin
         close_frame();
      end else begin
         case (scan_state)
            SCAN_IDENT: take_ident_char(q.character);
            SCAN_DELIM: begin
               if (q.character == CH_R_UPPER || q.character == CH_R_LOWER) begin
                  id_acc[FLAG_RTR_BIT] = 1'b1;
                  scan_state = SCAN_DLC;
               end else if (q.character == CH_HASH) begin
                  fd_frame   = 1'b1;
                  scan_state = SCAN_FLAGS;
               end else begin
                  scan_state = SCAN_BYTE_HI;
                  take_data_char(q.character);
               end
            end
            SCAN_FLAGS: begin
               n = nibble_of(q.character);
               if (n[4]) begin
                  scan_state = SCAN_BAD;
               end else begin
                  flag_nibble = n[3:0];
                  scan_state  = SCAN_BYTE_HI;
               end
            end
            SCAN_BYTE_HI, SCAN_AFTER_DOT, SCAN_BYTE_LO: take_data_char(q.character);
            SCAN_DLC: begin
               // digits above 8, or no digit, leave the length at zero
               n = nibble_of(q.character);
               if (n <= 5'd8) begin
                  byte_count = n;
               end
               scan_state = SCAN_DONE;
            end
            default: ;
         endcase
      end
   endfunction

   function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Driver: presents queued requests, holding valid and payload steady
   // until accepted. A held item waits for a fully drained result side,
   // with valid dropped first so that the terminator just taken has been
   // turned into owed results.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct &&
             (!pending[0].hold || (!req_valid && drained))) begin
            head_item    = pending.pop_front();
            req_valid   <= 1'b1;
            req_payload <= head_item.payload;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------
   // Monitor: checks each result against the oldest owed one, then feeds
   // any accepted request to the decoder. A result can never stem from a
   // request taken at the same edge, so this order is safe.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         drained <= 1'b1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (bytes_due.size() == 0) begin
               $error("result with nothing owed: 0x%0h", rsp_payload);
               mismatches++;
            end else begin
               check_field("verdict", bytes_due[0].verdict, rsp_payload.verdict);
               check_field("frame_id", bytes_due[0].frame_id, rsp_payload.frame_id);
               check_field("fd_flags", bytes_due[0].fd_flags, rsp_payload.fd_flags);
               check_field("data_length", bytes_due[0].data_length,
                           rsp_payload.data_length);
               check_field("byte_index", bytes_due[0].byte_index, rsp_payload.byte_index);
               check_field("data_byte", bytes_due[0].data_byte, rsp_payload.data_byte);
               check_field("last", bytes_due[0].last, rsp_payload.last);
               void'(bytes_due.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            requests_taken++;
            parse_request(req_payload);
         end
         drained <= (bytes_due.size() == 0);
      end
   end

   // Watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ascii_can_frame_parser regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_char(logic [7:0] c);
      pending_item_type item;
      item.payload.character  = c;
      item.payload.terminator = 1'b0;
      item.hold               = hold_next;
      hold_next               = 1'b0;
      pending.push_back(item);
      chars_queued++;
   endtask

   // character field carries junk on terminators; the block must ignore it
   task automatic queue_end();
      pending_item_type item;
      item.payload.character  = 8'($urandom_range(255));
      item.payload.terminator = 1'b1;
      item.hold               = hold_next;
      hold_next               = 1'b0;
      pending.push_back(item);
   endtask

   task automatic queue_frame(string s);
      for (int i = 0; i < s.len(); i++) begin
         queue_char(s[i]);
      end
      queue_end();
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) begin
         return 8'h30 + v;
      end
      return ($urandom_range(1) ? 8'h41 : 8'h61) + v - 8'd10;
   endfunction

   // Mostly well-formed strings with random content; some are then cut
   // short or have one character spoilt, and some are plain noise
   task automatic random_frame();
      logic [7:0] text [$];
      int dice, nbytes, digits, pos;
      dice = $urandom_range(99);
      if (dice >= 85) begin
         nbytes = $urandom_range(10);
         for (int k = 0; k < nbytes; k++) begin
            text.push_back(8'($urandom_range(255)));
         end
         if (nbytes > 3 && $urandom_range(2) == 0) begin
            text[3] = CH_HASH;
         end
      end else begin
         digits = ($urandom_range(3) == 0) ? 8 : 3;
         for (int k = 0; k < digits; k++) begin
            text.push_back(hex_char(4'($urandom_range(15))));
         end
         text.push_back(CH_HASH);
         case ($urandom_range(5))
            0, 1, 2: nbytes = $urandom_range(9);
            3, 4: begin
               text.push_back(CH_HASH);
               text.push_back(hex_char(4'($urandom_range(15))));
               nbytes = ($urandom_range(15) == 0) ? $urandom_range(66) : $urandom_range(12);
            end
            default: begin
               text.push_back($urandom_range(1) ? CH_R_UPPER : CH_R_LOWER);
               nbytes = 0;
               case ($urandom_range(3))
                  1: text.push_back(8'h30 + 8'($urandom_range(8)));
                  2: text.push_back(8'($urandom_range(255)));
                  3: begin
                     text.push_back(hex_char(4'($urandom_range(15))));
                     text.push_back(8'($urandom_range(255)));
                  end
                  default: ;
               endcase
            end
         endcase
         for (int k = 0; k < nbytes; k++) begin
            if ($urandom_range(3) == 0) begin
               text.push_back(CH_DOT);
            end
            text.push_back(hex_char(4'($urandom_range(15))));
            text.push_back(hex_char(4'($urandom_range(15))));
         end
         if (dice >= 68) begin
            pos = $urandom_range(text.size() - 1);
            if ($urandom_range(1)) begin
               while (text.size() > pos) begin
                  void'(text.pop_back());
               end
            end else begin
               text[pos] = 8'($urandom_range(255));
            end
         end
      end
      if ($urandom_range(9) == 0) begin
         hold_next = 1'b1;
      end
      foreach (text[i]) begin
         queue_char(text[i]);
      end
      queue_end();
   endtask

   task automatic random_phase();
      int unsigned start;
      start = chars_queued;
      while (chars_queued - start < PHASE_CHARS) begin
         random_frame();
      end
   endtask

   // Everything sent, accepted and answered
   task automatic wait_idle();
      do @(posedge clock); while (pending.size() != 0 || req_valid || !drained);
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // phase one: occasional sender gaps, receiver stalls most cycles
      send_gap_pct  = 7;
      rsp_stall_pct = 67;

      queue_frame("123#");                        // empty data, still valid
      queue_frame("7FF#DEADBEEF");
      queue_frame("000#11.22.33.44.55.66.77.88"); // dotted, classic limit
      queue_frame("123#1122334455667788zz99");    // overflow, junk ignored
      queue_frame("12345678#00");                 // extended identifier
      queue_frame("3FFFFFFF#ab");                 // error bit set, no extended
      queue_frame("FFFFFFFF#12");                 // remote bit from the digits
      queue_frame("123#R");                       // remote, no DLC
      queue_frame("1AB#r8");
      queue_frame("123#R9");                      // DLC out of range
      queue_frame("123#R5xyz");                   // junk after DLC ignored
      queue_frame("123##");                       // cut off after double '#'
      queue_frame("123##F");
      queue_frame("12");                          // cut off inside identifier
      queue_frame("123#1");                       // cut off between digits
      queue_frame("12G#11");                      // bad identifier digit
      queue_frame("1Z3#");
      queue_frame("123#1G");                      // bad data digit
      queue_frame("123#..11");                    // dot twice
      queue_frame("123##G1");                     // bad flags digit
      queue_frame("123456789#");                  // ninth char not '#'
      queue_frame("123#.");                       // lone dot is still valid
      queue_frame("");                            // bare terminator
      queue_char("1"); queue_char("2"); queue_char("3"); queue_char(CH_HASH);
      queue_char(8'h00);                          // NUL is just a bad digit
      queue_end();
      // full FD frame with a drained result side first, then excess text
      hold_next = 1'b1;
      queue_char("5"); queue_char("5"); queue_char("5");
      queue_char(CH_HASH); queue_char(CH_HASH); queue_char("A");
      for (int k = 0; k < MAX_DATA_BYTES; k++) begin
         queue_char(hex_char(4'(k >> 4)));
         queue_char(hex_char(4'(k + 7)));
      end
      queue_char("G"); queue_char("G");
      queue_end();

      random_phase();
      wait_idle();

      // phase two: sender gaps most cycles, receiver rarely stalls
      send_gap_pct  = 67;
      rsp_stall_pct = 7;
      random_phase();
      wait_idle();

      // phase three: full rate both sides
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      random_phase();
      wait_idle();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (bytes_due.size() != 0) begin
         $error("%0d owed results never arrived", bytes_due.size());
         mismatches++;
      end

      $display("Fed %0d characters and terminators as %0d frames; checked %0d results",
               requests_taken, frames_closed, results_checked);
      $display("under three pacing mixes, with %0d field mismatches", mismatches);
      if (mismatches == 0) begin
         $display("ascii_can_frame_parser regression: pass");
      end else begin
         $display("ascii_can_frame_parser regression: fail");
      end
      $finish;
   end

endmodule
